### rtl/core/rhci_pkg.sv
package rhci_pkg;

  // Angles are 32-bit fractions of a full turn.
  localparam int ANGLE_BITS   = 32;
  localparam int CORDIC_STEPS = 31;
  localparam int FRAC_SHIFT   = 24;

  // sqrt(3) in Q24.
  localparam logic [24:0] SQRT3_Q24 = 25'd29058991;

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) as a fraction of a turn, rounded.
  function automatic logic [ANGLE_BITS-1:0] atan_turn(input int unsigned idx);
    logic [ANGLE_BITS-1:0] a;
    unique case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/rhci_front.sv
module rhci_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        red,
  input  logic [SAMPLE_BITS-1:0]        green,
  input  logic [SAMPLE_BITS-1:0]        blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS+1:0] dx,
  output logic signed [SAMPLE_BITS:0]   dy,
  output logic signed [SAMPLE_BITS:0]   d1,
  output logic signed [SAMPLE_BITS:0]   d3,
  output logic [SAMPLE_BITS+1:0]        sum_p1,
  output logic                          gray
);
  localparam int EW = SAMPLE_BITS + 2;

  logic              adv;
  logic signed [EW-1:0] r_e, g_e, b_e;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign r_e = signed'({2'b00, red});
  assign g_e = signed'({2'b00, green});
  assign b_e = signed'({2'b00, blue});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv && in_valid) begin
      dx     <= (r_e <<< 1) - g_e - b_e;
      dy     <= (SAMPLE_BITS+1)'(g_e - b_e);
      d1     <= (SAMPLE_BITS+1)'(r_e - g_e);
      d3     <= (SAMPLE_BITS+1)'(b_e - r_e);
      sum_p1 <= EW'(unsigned'(r_e)) + EW'(unsigned'(g_e)) + EW'(unsigned'(b_e)) + EW'(1);
      gray   <= (red == green) && (green == blue);
    end
  end

endmodule

### rtl/core/rhci_queue.sv
module rhci_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

### rtl/core/rhci_back.sv
module rhci_back #(
  parameter int SAMPLE_BITS = 12,
  parameter int HUE_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS+1:0] dx,
  input  logic signed [SAMPLE_BITS:0]   dy,
  input  logic signed [SAMPLE_BITS:0]   d1,
  input  logic signed [SAMPLE_BITS:0]   d3,
  input  logic [SAMPLE_BITS+1:0]        sum_p1,
  input  logic                          gray,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [HUE_BITS-1:0]           hue,
  output logic                          hue_valid,
  output logic [SAMPLE_BITS-1:0]        chroma,
  output logic [SAMPLE_BITS-1:0]        intensity
);
  import rhci_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int NW     = S + 2;
  localparam int K      = S + 3;
  localparam int MW     = S + 2;
  localparam logic [MW-1:0] RECIP3 = MW'((64'd1 << K) / 3);
  localparam int PW     = NW + MW;
  localparam int SQW    = 2 * S;
  localparam int VW     = 2 * S + 3;
  localparam int SQ_STEPS = (VW + 1) / 2;
  localparam int RW     = 2 * SQ_STEPS + 1;
  localparam int YW     = S + 27;
  localparam int CW     = S + 29;
  localparam int N      = CORDIC_STEPS;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage A: the multiplies.
  logic                 a_valid;
  logic [SQW-1:0]       a_sq1, a_sq2, a_sq3;
  logic [PW-1:0]        a_qprod;
  logic [NW-1:0]        a_n;
  logic signed [NW-1:0] a_dx;
  logic signed [YW-1:0] a_y;
  logic                 a_gray;
  logic signed [2*S+1:0] p1, p2, p3;
  logic signed [YW-1:0]  py;
  logic signed [25:0]    k3;

  assign k3 = signed'({1'b0, SQRT3_Q24});
  assign p1 = d1 * d1;
  assign p2 = dy * dy;
  assign p3 = d3 * d3;
  assign py = dy * k3;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_sq1   <= p1[SQW-1:0];
      a_sq2   <= p2[SQW-1:0];
      a_sq3   <= p3[SQW-1:0];
      a_qprod <= PW'(sum_p1) * PW'(RECIP3);
      a_n     <= sum_p1;
      a_dx    <= dx;
      a_y     <= py;
      a_gray  <= gray;
    end
  end

  // Stage B and the CORDIC / square-root stages.
  logic                  sv   [N+1];
  logic signed [CW-1:0]  sx   [N+1];
  logic signed [CW-1:0]  sy   [N+1];
  logic [ANGLE_BITS-1:0] sz   [N+1];
  logic [RW-1:0]         s_v  [N+1];
  logic [RW-1:0]         s_r  [N+1];
  logic                  sg   [N+1];
  logic [S-1:0]          si   [N+1];

  logic [S:0]            q_est;
  logic [S+2:0]          rem3;
  logic signed [CW-1:0]  x_init, y_init;
  logic [VW-2:0]         sq_sum;

  assign q_est  = a_qprod[PW-1:K];
  assign rem3   = (S+3)'(a_n) - ((S+3)'(q_est) + ((S+3)'(q_est) << 1));
  assign x_init = CW'(a_dx) <<< FRAC_SHIFT;
  assign y_init = CW'(a_y);
  assign sq_sum = (VW-1)'(a_sq1) + (VW-1)'(a_sq2) + (VW-1)'(a_sq3);

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= a_valid;
    end
    if (adv) begin
      if (a_dx < 0) begin
        sx[0] <= -x_init;
        sy[0] <= -y_init;
        sz[0] <= HALF_TURN;
      end else begin
        sx[0] <= x_init;
        sy[0] <= y_init;
        sz[0] <= '0;
      end
      s_v[0] <= RW'({sq_sum, 1'b0});
      s_r[0] <= '0;
      sg[0]  <= a_gray;
      si[0]  <= (rem3 >= (S+3)'(3)) ? S'(q_est + (S+1)'(1)) : S'(q_est);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    assign bitv  = (i < SQ_STEPS) ? (RW'(1) << (2 * (SQ_STEPS - 1 - i))) : '0;
    assign trial = s_r[i] + bitv;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else if (adv) begin
        sv[i+1] <= sv[i];
      end
      if (adv) begin
        if (sy[i] >= 0) begin
          sx[i+1] <= sx[i] + (sy[i] >>> i);
          sy[i+1] <= sy[i] - (sx[i] >>> i);
          sz[i+1] <= sz[i] + atan_turn(i);
        end else begin
          sx[i+1] <= sx[i] - (sy[i] >>> i);
          sy[i+1] <= sy[i] + (sx[i] >>> i);
          sz[i+1] <= sz[i] - atan_turn(i);
        end
        if (i >= SQ_STEPS) begin
          s_v[i+1] <= s_v[i];
          s_r[i+1] <= s_r[i];
        end else if (s_v[i] >= trial) begin
          s_v[i+1] <= s_v[i] - trial;
          s_r[i+1] <= (s_r[i] >> 1) + bitv;
        end else begin
          s_v[i+1] <= s_v[i];
          s_r[i+1] <= s_r[i] >> 1;
        end
        sg[i+1] <= sg[i];
        si[i+1] <= si[i];
      end
    end
  end

  // Output register: hue rounding and chroma saturation.
  logic [ANGLE_BITS-1:0] z_round;
  logic [RW-1:0]         c_round;

  assign z_round = sz[N] + (ANGLE_BITS'(1) << (31 - HUE_BITS));
  assign c_round = (s_r[N] + RW'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sv[N];
    end
    if (adv) begin
      hue       <= sg[N] ? '0 : z_round[ANGLE_BITS-1 -: HUE_BITS];
      hue_valid <= !sg[N];
      chroma    <= (c_round > RW'({S{1'b1}})) ? {S{1'b1}} : c_round[S-1:0];
      intensity <= si[N];
    end
  end

endmodule

### rtl/core/rgb_to_hue_chroma_intensity.sv
// RGB to hue, chroma and intensity converter.
//
// Input channel: in_valid / in_ready carry one pixel (red, green, blue), each an
// unsigned fraction scaled by 2^SAMPLE_BITS-1. A transfer happens on a rising
// edge with valid and ready both high.
// Output channel: out_valid / out_ready carry hue (a fraction of a turn over
// HUE_BITS), hue_valid (low for gray pixels, with hue forced to zero), chroma
// and intensity, one result per pixel and in order.
// Throughput is one pixel per clock while the receiver accepts results. An
// input transfer loads the front register, then passes through one queue slot,
// stage A (the multiplies), stage B, one stage per CORDIC iteration (31) and
// the output register. The CORDIC pipeline sets the depth; the square root
// rides along in its first stages.
// When the receiver stalls, the whole back pipeline holds; the front keeps
// taking pixels until the two-entry queue fills, then drops in_ready.
// Reset (rst, synchronous) empties the queue and clears every valid bit.
module rgb_to_hue_chroma_intensity #(
  parameter int SAMPLE_BITS = 12,
  parameter int HUE_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] red,
  input  logic [SAMPLE_BITS-1:0] green,
  input  logic [SAMPLE_BITS-1:0] blue,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [HUE_BITS-1:0]    hue,
  output logic                   hue_valid,
  output logic [SAMPLE_BITS-1:0] chroma,
  output logic [SAMPLE_BITS-1:0] intensity
);
  import rhci_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int QW = 5 * S + 8;

  // Front side: differences, component sum and the gray flag.
  logic                f_valid, f_ready;
  logic signed [S+1:0] f_dx;
  logic signed [S:0]   f_dy, f_d1, f_d3;
  logic [S+1:0]        f_n;
  logic                f_gray;

  // Queue output as seen by the back side.
  logic                q_valid, q_ready;
  logic [QW-1:0]       q_data;
  logic signed [S+1:0] q_dx;
  logic signed [S:0]   q_dy, q_d1, q_d3;
  logic [S+1:0]        q_n;
  logic                q_gray;

  rhci_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .dx       (f_dx),
    .dy       (f_dy),
    .d1       (f_d1),
    .d3       (f_d3),
    .sum_p1   (f_n),
    .gray     (f_gray)
  );

  rhci_queue #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  ({f_dx, f_dy, f_d1, f_d3, f_n, f_gray}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_data)
  );

  assign {q_dx, q_dy, q_d1, q_d3, q_n, q_gray} = q_data;

  // Back side: squares, CORDIC vectoring, square root and output register.
  rhci_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .HUE_BITS   (HUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .dx       (q_dx),
    .dy       (q_dy),
    .d1       (q_d1),
    .d3       (q_d3),
    .sum_p1   (q_n),
    .gray     (q_gray),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hue      (hue),
    .hue_valid(hue_valid),
    .chroma   (chroma),
    .intensity(intensity)
  );

`ifndef SYNTHESIS
  // A gray pixel has no hue and no chroma.
  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hue_valid |-> hue == '0 && chroma == '0)
    else $error("gray pixel with nonzero hue or chroma");

  // Any colored pixel has at least one unit of chroma.
  a_color_chroma: assert property (@(posedge clk) disable iff (rst)
    out_valid && hue_valid |-> chroma != '0)
    else $error("colored pixel with zero chroma");

  // Nothing leaves the block right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented right after reset");
`endif

endmodule
